>>> sv/ps2ks_pkg.sv
`timescale 1ns / 1ps

package ps2ks_pkg;

  localparam int KeyCount    = 256;
  localparam int IdxW        = $clog2(KeyCount);
  localparam int StatusW     = 2;
  localparam int OpcodeW     = 2;
  localparam int ByteW       = 8;

  localparam logic [ByteW-1:0]   CodeRelease  = 8'hF0;
  localparam logic [ByteW-1:0]   CodeExtended = 8'hE0;
  localparam logic [StatusW-1:0] HeldBit      = 2'b01;
  localparam logic [StatusW-1:0] PressedBit   = 2'b10;

  // request opcodes
  typedef enum logic [OpcodeW-1:0] {
    OP_BYTE  = 2'd0,
    OP_TEST  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // what a decoded request does to the key table
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PRESS,
    KIND_RELEASE,
    KIND_TEST,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [IdxW-1:0] idx;
  } req_t;

endpackage

>>> sv/ps2ks_ram.sv
`timescale 1ns / 1ps

module ps2ks_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ps2ks_decode.sv
`timescale 1ns / 1ps

module ps2ks_decode
  import ps2ks_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [OpcodeW-1:0] opcode,
  input  logic [ByteW-1:0]   data_byte,
  output req_t               req
);

  logic rel_pend_r, rel_pend_nxt;
  logic ext_pend_r, ext_pend_nxt;

  always_comb begin
    req.kind     = KIND_NONE;
    req.idx      = data_byte;
    rel_pend_nxt = rel_pend_r;
    ext_pend_nxt = ext_pend_r;
    case (opcode)
      OP_BYTE: begin
        if (data_byte == CodeRelease) begin
          rel_pend_nxt = 1'b1;
        end else if (data_byte == CodeExtended) begin
          ext_pend_nxt = 1'b1;
        end else begin
          // extended keys live in the upper half of the table
          req.idx      = ext_pend_r ? {1'b1, data_byte[6:0]} : data_byte;
          req.kind     = rel_pend_r ? KIND_RELEASE : KIND_PRESS;
          rel_pend_nxt = 1'b0;
          ext_pend_nxt = 1'b0;
        end
      end
      OP_TEST:  req.kind = KIND_TEST;
      OP_CLEAR: req.kind = KIND_CLEAR;
      default:  req.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_pend_r <= 1'b0;
      ext_pend_r <= 1'b0;
    end else if (accept) begin
      rel_pend_r <= rel_pend_nxt;
      ext_pend_r <= ext_pend_nxt;
    end
  end

endmodule

>>> sv/ps2_key_state_tracker_core.sv
`timescale 1ns / 1ps

// ps2 key state tracker
// input channel (in_valid/in_ready) carries one request per item:
//   in_opcode 0 feeds a raw set-2 scancode byte, 1 tests a key and clears its
//   pressed-since-tested bit, 2 clears every key; opcode 3 does nothing
// result channel (out_valid/out_ready) returns exactly one out_key_status per
//   request, in order: bit0 held, bit1 pressed since last test, zero unless testing
// a request accepted at an edge passes through stage 1 and then the result register;
//   throughput is one request per cycle unless the receiver stalls, the key table
//   memory being read when a request enters and written back as it leaves stage 1
// reset clears the prefix flags, the per-key valid bits (so the whole table
//   reads as zero at once, no clearing pass) and both pipeline stages
// when the receiver stalls the result register holds, the stage behind it
//   holds its request, and in_ready drops until the result is taken
module ps2_key_state_tracker_core
  import ps2ks_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OpcodeW-1:0] in_opcode,
  input  logic [ByteW-1:0]   in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [StatusW-1:0] out_key_status
);

  logic   in_acc;
  req_t   dec_req;

  // stage 1: request waiting for its table read
  logic   s1_vld_r;
  req_t   s1_req_r;
  logic   s1_adv;

  // result register
  logic               out_vld_r;
  logic [StatusW-1:0] out_stat_r;

  // table: memory plus one valid bit per key, valid clear means all zero
  logic [KeyCount-1:0] key_vld_r;
  logic [StatusW-1:0]  ram_q;
  logic                wr_en;
  logic [StatusW-1:0]  wr_data;

  // write that landed on the same edge as the stage 1 read
  logic               byp_vld_r;
  logic [IdxW-1:0]    byp_idx_r;
  logic [StatusW-1:0] byp_data_r;

  logic [StatusW-1:0] old_stat;
  logic [StatusW-1:0] res_stat;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  ps2ks_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .req       (dec_req)
  );

  ps2ks_ram #(
    .WIDTH (StatusW),
    .DEPTH (KeyCount)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_req_r.idx),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (dec_req.idx),
    .rdata (ram_q)
  );

  // current status of the stage 1 key, newest write first
  always_comb begin
    if (!key_vld_r[s1_req_r.idx]) begin
      old_stat = '0;
    end else if (byp_vld_r && (byp_idx_r == s1_req_r.idx)) begin
      old_stat = byp_data_r;
    end else begin
      old_stat = ram_q;
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_data  = old_stat;
    res_stat = '0;
    case (s1_req_r.kind)
      KIND_PRESS: begin
        wr_en   = s1_adv;
        wr_data = HeldBit | PressedBit;
      end
      KIND_RELEASE: begin
        wr_en   = s1_adv;
        wr_data = old_stat & ~HeldBit;
      end
      KIND_TEST: begin
        wr_en    = s1_adv;
        wr_data  = old_stat & ~PressedBit;
        res_stat = old_stat;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      byp_vld_r <= 1'b0;
      key_vld_r <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r  <= 1'b1;
        byp_vld_r <= wr_en;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end

      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end

      if (s1_adv && (s1_req_r.kind == KIND_CLEAR)) begin
        key_vld_r <= '0;
      end else if (wr_en) begin
        key_vld_r[s1_req_r.idx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r   <= dec_req;
      byp_idx_r  <= s1_req_r.idx;
      byp_data_r <= wr_data;
    end
    if (s1_adv) begin
      out_stat_r <= res_stat;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_key_status = out_stat_r;

endmodule

>>> sv/ps2ks_checker.sv
`timescale 1ns / 1ps

module ps2ks_checker
  import ps2ks_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OpcodeW-1:0] in_opcode,
  input logic [ByteW-1:0]   in_data_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [StatusW-1:0] out_key_status
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_status))
    else $error("stalled result changed");

  // testing the same key twice in a row: second test sees no fresh press
  a_test_twice: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == OP_TEST) ##1
    (in_acc && in_opcode == OP_TEST && in_data_byte == $past(in_data_byte) && out_ready)
    ##1 out_ready |=> out_valid && !out_key_status[1])
    else $error("pressed bit survived a test");

  // a test right after clear-all reads zero
  a_clear_test: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == OP_CLEAR) ##1
    (in_acc && in_opcode == OP_TEST && out_ready)
    ##1 out_ready |=> out_valid && out_key_status == '0)
    else $error("key status nonzero after clear");

endmodule

bind ps2_key_state_tracker_core ps2ks_checker u_ps2ks_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ps2ks_pkg::*;

  // opcode 3 has no enum member, the block must ignore it
  localparam logic [OpcodeW-1:0] OpNone     = 2'd3;
  localparam int                 ReqTotal   = 1100;
  localparam int                 QuietTail  = 150;
  localparam int                 DrainAt    = 500;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OpcodeW-1:0] in_opcode;
  logic [ByteW-1:0]   in_data_byte;
  logic               out_valid;
  logic               out_ready;
  logic [StatusW-1:0] out_key_status;

  ps2_key_state_tracker_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_status (out_key_status)
  );

  // shadow copy of the key table and the prefix flags
  logic [StatusW-1:0] key_tbl [KeyCount];
  logic               release_flag;
  logic               ext_flag;
  logic [IdxW-1:0]    last_key;

  logic [StatusW-1:0] status_due [$];
  logic [StatusW-1:0] want_status;
  int                 mismatches;
  int                 reqs_sent;
  bit                 idle_on;

  // directed rows: typed = 1 means the status column is the expected value
  typedef struct packed {
    logic [OpcodeW-1:0] op;
    logic [ByteW-1:0]   data;
    bit                 typed;
    logic [StatusW-1:0] status;
  } dir_row_t;

  dir_row_t dir_rows [24] = '{
    // empty table right after reset, lowest and highest key
    '{OP_TEST,  8'h00, 1'b1, 2'd0},
    '{OP_TEST,  8'hFF, 1'b1, 2'd0},
    // plain press, test twice: second test sees only the held bit
    '{OP_BYTE,  8'h1C, 1'b1, 2'd0},
    '{OP_TEST,  8'h1C, 1'b1, HeldBit | PressedBit},
    '{OP_TEST,  8'h1C, 1'b1, HeldBit},
    // release of the same key
    '{OP_BYTE,  CodeRelease, 1'b1, 2'd0},
    '{OP_BYTE,  8'h1C, 1'b1, 2'd0},
    '{OP_TEST,  8'h1C, 1'b1, 2'd0},
    // repeated extended prefix, then top code maps to the last key
    '{OP_BYTE,  CodeExtended, 1'b1, 2'd0},
    '{OP_BYTE,  CodeExtended, 1'b1, 2'd0},
    '{OP_BYTE,  8'hFF, 1'b1, 2'd0},
    '{OP_TEST,  8'hFF, 1'b1, HeldBit | PressedBit},
    // press then release without a test keeps the pressed bit
    '{OP_BYTE,  8'h05, 1'b0, 2'd0},
    '{OP_BYTE,  CodeRelease, 1'b0, 2'd0},
    '{OP_BYTE,  CodeRelease, 1'b0, 2'd0},
    '{OP_BYTE,  8'h05, 1'b0, 2'd0},
    '{OP_TEST,  8'h05, 1'b0, 2'd0},
    // clear all in the middle of an extended sequence keeps the prefix
    '{OP_BYTE,  8'h00, 1'b0, 2'd0},
    '{OP_BYTE,  CodeExtended, 1'b0, 2'd0},
    '{OP_CLEAR, 8'h00, 1'b1, 2'd0},
    '{OP_BYTE,  8'h11, 1'b0, 2'd0},
    '{OP_TEST,  8'h91, 1'b0, 2'd0},
    '{OP_TEST,  8'h00, 1'b1, 2'd0},
    // unused opcode does nothing
    '{OpNone,   8'hAA, 1'b1, 2'd0}
  };

  // updates the shadow state for one request and returns its key status
  function automatic logic [StatusW-1:0] apply_request(input logic [OpcodeW-1:0] op,
                                                       input logic [ByteW-1:0] b);
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    idx;
    status = '0;
    case (op)
      OP_BYTE: begin
        if (b == CodeRelease) begin
          release_flag = 1'b1;
        end else if (b == CodeExtended) begin
          ext_flag = 1'b1;
        end else begin
          // extended keys live in the upper half, low 7 bits of the code
          idx = ext_flag ? {1'b1, b[6:0]} : b;
          if (release_flag) key_tbl[idx] = key_tbl[idx] & ~HeldBit;
          else key_tbl[idx] = HeldBit | PressedBit;
          release_flag = 1'b0;
          ext_flag     = 1'b0;
          last_key     = idx;
        end
      end
      OP_TEST: begin
        status     = key_tbl[b];
        key_tbl[b] = key_tbl[b] & ~PressedBit;
      end
      OP_CLEAR: begin
        foreach (key_tbl[i]) key_tbl[i] = '0;
      end
      default: ;
    endcase
    return status;
  endfunction

  // key code byte that is neither prefix, mostly from a small set of keys
  function automatic logic [ByteW-1:0] pick_code();
    logic [ByteW-1:0] b;
    b = CodeRelease;
    while (b == CodeRelease || b == CodeExtended) begin
      if ($urandom_range(0, 1) == 0) b = 8'h10 + 8'($urandom_range(0, 7));
      else b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // key index to test: recent key, small key set (either half) or anything
  function automatic logic [ByteW-1:0] pick_test_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return last_key;
    if (sel < 7) return {1'($urandom_range(0, 1)), 7'h10 + 7'($urandom_range(0, 7))};
    return 8'($urandom_range(0, 255));
  endfunction

  // offers one request and records its expected status when it is taken
  task automatic put_req(input logic [OpcodeW-1:0] op, input logic [ByteW-1:0] b,
                         input bit typed, input logic [StatusW-1:0] typed_status);
    logic [StatusW-1:0] pred;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = apply_request(op, b);
    status_due.push_back(typed ? typed_status : pred);
    reqs_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: stall bursts while idling is on
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key_status %0d",
                 $time, out_key_status);
        mismatches++;
      end else begin
        want_status = status_due.pop_front();
        if (out_key_status !== want_status) begin
          $display("%0t: key_status expected %0d actual %0d",
                   $time, want_status, out_key_status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int sel;
    int next_mode_at;
    bit drained;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= OP_BYTE;
    in_data_byte <= '0;
    mismatches   = 0;
    reqs_sent    = 0;
    idle_on      = 1'b1;
    drained      = 1'b0;
    next_mode_at = 100;
    release_flag = 1'b0;
    ext_flag     = 1'b0;
    last_key     = '0;
    foreach (key_tbl[i]) key_tbl[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      put_req(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].status);

    while (reqs_sent < ReqTotal) begin
      if (reqs_sent >= ReqTotal - QuietTail) begin
        idle_on = 1'b0;
      end else if (reqs_sent >= next_mode_at) begin
        idle_on = $urandom_range(0, 3) != 0;
        next_mode_at += 100;
      end
      // hold the sender until the pipeline has drained once
      if (!drained && reqs_sent >= DrainAt) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (status_due.size() != 0);
        drained = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        // well-formed scancode: optional extended prefix, optional break
        if ($urandom_range(0, 2) == 0) put_req(OP_BYTE, CodeExtended, 1'b0, '0);
        if ($urandom_range(0, 2) == 0) put_req(OP_BYTE, CodeRelease, 1'b0, '0);
        put_req(OP_BYTE, pick_code(), 1'b0, '0);
      end else if (sel < 82) begin
        put_req(OP_TEST, pick_test_key(), 1'b0, '0);
      end else if (sel < 92) begin
        // noise: any raw byte, prefixes included
        put_req(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (sel < 97) begin
        put_req(OpNone, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        put_req(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
sv/ps2ks_pkg.sv
sv/ps2ks_ram.sv
sv/ps2ks_decode.sv
sv/ps2_key_state_tracker_core.sv
sv/ps2ks_checker.sv
dv/tb_top.sv
